/* sv/vaft_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the full-turn vector angle pipeline.
package vaft_pkg;

    // Field widths
    localparam int INPUT_BITS    = 16;
    localparam int OUT_W         = 16;

    // CORDIC configuration
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int GUARD_BITS    = 8;

    // x/y datapath: sign, one bit for -min negation, guard bits, two bits of CORDIC growth
    localparam int XY_W          = INPUT_BITS + GUARD_BITS + 3;

    // Angle datapath, units of 2^-24 rad
    localparam int ANG_FRAC      = 24;
    localparam int OUT_FRAC      = 13;
    localparam int RND_SHIFT     = ANG_FRAC - OUT_FRAC;
    localparam int Z_W           = 28;
    localparam int TOT_W         = Z_W - 1;

    localparam logic signed [Z_W-1:0] PI_FIX     = 28'sd52707179;
    localparam logic signed [Z_W-1:0] TWO_PI_FIX = 28'sd105414357;
    localparam logic [TOT_W:0]        RND_HALF   = (TOT_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [OUT_W:0]        FULL_TURN_OUT = 17'd51472;

    // atan(2^-i) * 2^24, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    // Payload carried through the rotation stages
    typedef struct packed {
        logic                  zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vec;

endpackage

/* sv/vaft_if.sv */
`timescale 1ns / 1ps
// Input channel: one vector per transaction.
interface vaft_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vaft_pkg::INPUT_BITS-1:0] x_coord;
    logic signed [vaft_pkg::INPUT_BITS-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// Output channel: one angle per transaction.
interface vaft_out_if;
    logic                            valid;
    logic                            ready;
    logic [vaft_pkg::OUT_W-1:0]      angle;
    logic                            zero_vector;

    modport source (output valid, output angle, output zero_vector, input ready);
    modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

/* sv/vaft_prerot.sv */
`timescale 1ns / 1ps
// Input stage: zero detect, turn left half-plane vectors by pi, add guard bits.
module vaft_prerot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vaft_in_if.sink        i_in,
    input  logic           i_ready,
    output logic           o_valid,
    output vaft_pkg::t_vec o_vec
);

    logic                                 r_valid;
    vaft_pkg::t_vec                       r_vec;
    vaft_pkg::t_vec                       n_vec;
    logic                                 w_en;
    logic                                 w_neg;
    logic signed [vaft_pkg::INPUT_BITS:0] w_x;
    logic signed [vaft_pkg::INPUT_BITS:0] w_y;
    logic signed [vaft_pkg::INPUT_BITS:0] w_xa;
    logic signed [vaft_pkg::INPUT_BITS:0] w_ya;

    localparam int EXT_W = vaft_pkg::XY_W - vaft_pkg::INPUT_BITS - 1 - vaft_pkg::GUARD_BITS;

    // Stage advances when empty or when downstream takes its content
    assign w_en       = !r_valid || i_ready;
    assign i_in.ready = w_en;

    // Rotate by pi when x is negative; widened by one bit so -min fits
    always_comb begin
        w_x   = {i_in.x_coord[vaft_pkg::INPUT_BITS-1], i_in.x_coord};
        w_y   = {i_in.y_coord[vaft_pkg::INPUT_BITS-1], i_in.y_coord};
        w_neg = i_in.x_coord[vaft_pkg::INPUT_BITS-1];
        w_xa  = w_neg ? -w_x : w_x;
        w_ya  = w_neg ? -w_y : w_y;
        n_vec.zero = (i_in.x_coord == '0) && (i_in.y_coord == '0);
        n_vec.x    = {{EXT_W{w_xa[vaft_pkg::INPUT_BITS]}}, w_xa, {vaft_pkg::GUARD_BITS{1'b0}}};
        n_vec.y    = {{EXT_W{w_ya[vaft_pkg::INPUT_BITS]}}, w_ya, {vaft_pkg::GUARD_BITS{1'b0}}};
        n_vec.z    = w_neg ? vaft_pkg::PI_FIX : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_in.valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

/* sv/vaft_cordic.sv */
`timescale 1ns / 1ps
// CORDIC vectoring pipeline: one micro-rotation per register stage.
module vaft_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vaft_pkg::t_vec i_vec,
    output logic           o_ready,
    output logic           o_valid,
    output vaft_pkg::t_vec o_vec,
    input  logic           i_ready
);

    logic [vaft_pkg::NUM_STAGES-1:0] r_v;
    vaft_pkg::t_vec                  r_s [vaft_pkg::NUM_STAGES];
    logic [vaft_pkg::NUM_STAGES:0]   w_en;

    assign w_en[vaft_pkg::NUM_STAGES] = i_ready;
    assign o_ready = w_en[0];

    for (genvar k = 0; k < vaft_pkg::NUM_STAGES; k++) begin : g_stage
        logic           w_pv;
        vaft_pkg::t_vec w_pd;
        vaft_pkg::t_vec n_s;
        logic signed [vaft_pkg::XY_W-1:0] w_xs;
        logic signed [vaft_pkg::XY_W-1:0] w_ys;

        if (k == 0) begin : g_first
            assign w_pv = i_valid;
            assign w_pd = i_vec;
        end else begin : g_next
            assign w_pv = r_v[k-1];
            assign w_pd = r_s[k-1];
        end

        // Stage ready ripples back from the output side
        assign w_en[k] = !r_v[k] || w_en[k+1];

        // Micro-rotation toward y = 0; shifts round toward minus infinity
        always_comb begin
            w_xs   = w_pd.x >>> k;
            w_ys   = w_pd.y >>> k;
            n_s    = w_pd;
            if (w_pd.y[vaft_pkg::XY_W-1]) begin
                n_s.x = w_pd.x - w_ys;
                n_s.y = w_pd.y + w_xs;
                n_s.z = w_pd.z - vaft_pkg::ATAN_TAB[k];
            end else begin
                n_s.x = w_pd.x + w_ys;
                n_s.y = w_pd.y - w_xs;
                n_s.z = w_pd.z + vaft_pkg::ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_pv) begin
                r_s[k] <= n_s;
            end
        end
    end

    assign o_valid = r_v[vaft_pkg::NUM_STAGES-1];
    assign o_vec   = r_s[vaft_pkg::NUM_STAGES-1];

endmodule

/* sv/vaft_finish.sv */
`timescale 1ns / 1ps
// Output stages: fold into [0, 2*pi), then round to 2^-13 rad and wrap a full turn.
module vaft_finish (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  vaft_pkg::t_vec i_vec,
    output logic           o_ready,
    vaft_out_if.source     o_out
);

    logic                          r1_v;
    logic                          r1_zero;
    logic [vaft_pkg::TOT_W-1:0]    r1_tot;
    logic [vaft_pkg::TOT_W-1:0]    n1_tot;
    logic signed [vaft_pkg::Z_W-1:0] w_fold;

    logic                          r2_v;
    logic                          r2_zero;
    logic [vaft_pkg::OUT_W-1:0]    r2_angle;
    logic [vaft_pkg::OUT_W-1:0]    n2_angle;
    logic [vaft_pkg::TOT_W:0]      w_sum;
    logic [vaft_pkg::OUT_W:0]      w_q;

    logic                          w_en1;
    logic                          w_en2;

    assign w_en2   = !r2_v || o_out.ready;
    assign w_en1   = !r1_v || w_en2;
    assign o_ready = w_en1;

    // Negative angles get a full turn added
    always_comb begin
        w_fold = i_vec.z[vaft_pkg::Z_W-1] ? (i_vec.z + vaft_pkg::TWO_PI_FIX) : i_vec.z;
        n1_tot = w_fold[vaft_pkg::TOT_W-1:0];
    end

    // Round half up, a result of exactly 2*pi wraps to zero
    always_comb begin
        w_sum = {1'b0, r1_tot} + vaft_pkg::RND_HALF;
        w_q   = w_sum[vaft_pkg::TOT_W:vaft_pkg::RND_SHIFT];
        if (r1_zero) begin
            n2_angle = '0;
        end else if (w_q >= vaft_pkg::FULL_TURN_OUT) begin
            n2_angle = vaft_pkg::OUT_W'(w_q - vaft_pkg::FULL_TURN_OUT);
        end else begin
            n2_angle = w_q[vaft_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_v <= i_valid;
            end
            if (w_en2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r1_tot  <= n1_tot;
            r1_zero <= i_vec.zero;
        end
        if (w_en2 && r1_v) begin
            r2_angle <= n2_angle;
            r2_zero  <= r1_zero;
        end
    end

    assign o_out.valid       = r2_v;
    assign o_out.angle       = r2_angle;
    assign o_out.zero_vector = r2_zero;

endmodule

/* sv/vector_angle_full_turn_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                        Handshake
// i_in      in   x_coord[15:0] s, y_coord[15:0] s valid/ready
// o_out     out  angle[15:0] u, zero_vector     valid/ready
//
// One input stage, 16 CORDIC micro-rotation stages, one fold stage and
// one rounding/output stage; one transaction per cycle unless stalled.
// i_rst_n is synchronous, active low, and clears only the stage valid bits.
// Each stage holds its item while the next one is full and stalled; ready
// ripples back stage by stage, so bubbles are squeezed out during a stall.
module vector_angle_full_turn_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vaft_in_if.sink    i_in,
    vaft_out_if.source o_out
);

    logic           w_pre_valid;
    vaft_pkg::t_vec w_pre_vec;
    logic           w_pre_ready;
    logic           w_cor_valid;
    vaft_pkg::t_vec w_cor_vec;
    logic           w_cor_ready;

    vaft_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (w_pre_ready),
        .o_valid (w_pre_valid),
        .o_vec   (w_pre_vec)
    );

    vaft_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pre_valid),
        .i_vec   (w_pre_vec),
        .o_ready (w_pre_ready),
        .o_valid (w_cor_valid),
        .o_vec   (w_cor_vec),
        .i_ready (w_cor_ready)
    );

    vaft_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cor_valid),
        .i_vec   (w_cor_vec),
        .o_ready (w_cor_ready),
        .o_out   (o_out)
    );

    // Angle always lies below a full turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.angle} < vaft_pkg::FULL_TURN_OUT))
        else $error("angle at or beyond a full turn");

    // A zero vector always reports angle zero
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_vector) |-> (o_out.angle == '0))
        else $error("zero vector with nonzero angle");

    // With the output stage empty, nothing can hold back the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output stage empty");

endmodule

/* sim/tb_vector_angle_full_turn_top.sv */
`timescale 1ns / 1ps
module tb_vector_angle_full_turn_top;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int DIRECTED_N   = 22;

    // Angle arithmetic in units of 2^-24 rad
    localparam longint ANG_PI       = 64'sd52707179;
    localparam longint ANG_TWO_PI   = 64'sd105414357;
    localparam longint ANG_FULL_OUT = 64'sd51472;
    localparam int     ROT_STAGES   = (vaft_pkg::CORDIC_STAGES > 24) ? 24
                                                                     : vaft_pkg::CORDIC_STAGES;

    localparam longint ARCTAN_STEP [24] = '{
        64'sd13176795, 64'sd7778716, 64'sd4110060, 64'sd2086331,
        64'sd1047214,  64'sd524117,  64'sd262123,  64'sd131069,
        64'sd65536,    64'sd32768,   64'sd16384,   64'sd8192,
        64'sd4096,     64'sd2048,    64'sd1024,    64'sd512,
        64'sd256,      64'sd128,     64'sd64,      64'sd32,
        64'sd16,       64'sd8,       64'sd4,       64'sd2
    };

    typedef struct packed {
        logic [vaft_pkg::OUT_W-1:0] angle;
        logic                       zero;
    } t_angle_res;

    // One vector to send; known marks a row with its answer typed in
    typedef struct {
        logic signed [vaft_pkg::INPUT_BITS-1:0] x;
        logic signed [vaft_pkg::INPUT_BITS-1:0] y;
        bit                                     known;
        logic [vaft_pkg::OUT_W-1:0]             angle;
        logic                                   zero;
    } t_vec_row;

    logic i_clk;
    logic i_rst_n;

    vaft_in_if  in_ch ();
    vaft_out_if out_ch ();

    vector_angle_full_turn_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock, 8 ns period
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Directed rows: axes, extremes, near-wrap points, zero vector
    t_vec_row directed_rows [DIRECTED_N] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd0, 1'b1},
        '{16'sd1,      16'sd0,      1'b0, 16'd0, 1'b0},
        '{16'sd32767,  16'sd0,      1'b0, 16'd0, 1'b0},
        '{-16'sd32768, 16'sd0,      1'b0, 16'd0, 1'b0},
        '{-16'sd1,     16'sd0,      1'b0, 16'd0, 1'b0},
        '{16'sd0,      16'sd32767,  1'b0, 16'd0, 1'b0},
        '{16'sd0,      -16'sd32768, 1'b0, 16'd0, 1'b0},
        '{16'sd0,      16'sd1,      1'b0, 16'd0, 1'b0},
        '{16'sd0,      -16'sd1,     1'b0, 16'd0, 1'b0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'd0, 1'b0},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'd0, 1'b0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'd0, 1'b0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'd0, 1'b0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0, 1'b0},
        '{16'sd1,      -16'sd1,     1'b0, 16'd0, 1'b0},
        '{16'sd32767,  -16'sd1,     1'b0, 16'd0, 1'b0},
        '{16'sd32767,  16'sd1,      1'b0, 16'd0, 1'b0},
        '{-16'sd32768, 16'sd1,      1'b0, 16'd0, 1'b0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'd0, 1'b0},
        '{16'sd0,      16'sd0,      1'b1, 16'd0, 1'b1},
        '{16'sd12345,  -16'sd23456, 1'b0, 16'd0, 1'b0},
        '{-16'sd21845, 16'sd10922,  1'b0, 16'd0, 1'b0}
    };

    t_vec_row   vec_stim [$];
    t_angle_res pending_angles [$];

    int       stim_idx;
    int       rx_count;
    int       err_count;
    int       cycle_count;
    bit       in_fire;
    t_vec_row cur_row;
    int       hold_left;
    bit       hold_done;

    // Bit-exact angle of one vector
    function automatic t_angle_res predict_angle(logic signed [vaft_pkg::INPUT_BITS-1:0] xc,
                                                 logic signed [vaft_pkg::INPUT_BITS-1:0] yc);
        longint     vx;
        longint     vy;
        longint     acc;
        longint     sx;
        longint     sy;
        t_angle_res res;
        if (xc == 0 && yc == 0) begin
            res.angle = '0;
            res.zero  = 1'b1;
            return res;
        end
        vx  = longint'(xc);
        vy  = longint'(yc);
        acc = 0;
        // Left half-plane: turn by pi first
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            acc = ANG_PI;
        end
        vx = vx * 256;
        vy = vy * 256;
        for (int i = 0; i < ROT_STAGES; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy < 0) begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ARCTAN_STEP[i];
            end else begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ARCTAN_STEP[i];
            end
        end
        if (acc < 0)
            acc = acc + ANG_TWO_PI;
        acc = (acc + 1024) >>> 11;
        // Rounded up to a full turn wraps to zero
        if (acc >= ANG_FULL_OUT)
            acc = acc - ANG_FULL_OUT;
        res.angle = acc[vaft_pkg::OUT_W-1:0];
        res.zero  = 1'b0;
        return res;
    endfunction

    function automatic logic signed [vaft_pkg::INPUT_BITS-1:0] pick_extreme();
        case ($urandom_range(5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // Random vector, weighted toward axes, small values and near-wrap points
    function automatic t_vec_row random_vector();
        t_vec_row r;
        r.known = 1'b0;
        r.angle = '0;
        r.zero  = 1'b0;
        case ($urandom_range(9))
            5: begin
                r.x = 16'($urandom_range(8) - 4);
                r.y = 16'($urandom_range(8) - 4);
            end
            6: begin
                if ($urandom_range(1)) begin
                    r.x = 16'sd0;
                    r.y = 16'($urandom);
                end else begin
                    r.x = 16'($urandom);
                    r.y = 16'sd0;
                end
            end
            7: begin
                r.x = pick_extreme();
                r.y = pick_extreme();
            end
            8: begin
                r.x = 16'($urandom_range(32767, 1));
                r.y = 16'($urandom_range(6) - 3);
            end
            9: begin
                r.x = 16'($urandom);
                r.y = $urandom_range(1) ? r.x : -r.x;
            end
            default: begin
                r.x = 16'($urandom);
                r.y = 16'($urandom);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d, result %0d: %s got %0d expected %0d",
                 cycle_count, rx_count, what, got, want);
        err_count++;
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_angle_res want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_vector_angle_full_turn_top NOT OK");
            $finish;
        end else begin
            in_fire = i_rst_n && in_ch.valid && in_ch.ready;
            if (in_fire) begin
                if (cur_row.known) begin
                    want.angle = cur_row.angle;
                    want.zero  = cur_row.zero;
                end else begin
                    want = predict_angle(in_ch.x_coord, in_ch.y_coord);
                end
                pending_angles.push_back(want);
            end
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_angles.size() == 0) begin
                    $display("unexpected transaction at cycle %0d: angle %0d zero %0d",
                             cycle_count, out_ch.angle, out_ch.zero_vector);
                    err_count++;
                end else begin
                    want = pending_angles.pop_front();
                    if (out_ch.angle !== want.angle)
                        report_mismatch("angle", int'(out_ch.angle), int'(want.angle));
                    if (out_ch.zero_vector !== want.zero)
                        report_mismatch("zero_vector", int'(out_ch.zero_vector),
                                        int'(want.zero));
                end
                rx_count++;
            end
        end
    end

    // Sender: holds a transaction until taken, otherwise idles or loads the next row
    always @(negedge i_clk) begin
        bit calm;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !in_fire)) begin
            calm = (stim_idx >= 250 && stim_idx < 400);
            if (stim_idx < vec_stim.size() && (calm || $urandom_range(99) >= 36)) begin
                cur_row = vec_stim[stim_idx];
                stim_idx++;
                in_ch.x_coord <= cur_row.x;
                in_ch.y_coord <= cur_row.y;
                in_ch.valid   <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off so the pipeline fills up
    always @(negedge i_clk) begin
        bit calm;
        calm = (rx_count >= 250 && rx_count < 400);
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && rx_count >= 80) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 36);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        out_ch.ready  = 1'b0;
        stim_idx      = 0;
        rx_count      = 0;
        err_count     = 0;
        cycle_count   = 0;
        in_fire       = 1'b0;
        hold_left     = 0;
        hold_done     = 1'b0;
        cur_row       = directed_rows[0];

        foreach (directed_rows[i])
            vec_stim.push_back(directed_rows[i]);
        repeat (RANDOM_ITEMS)
            vec_stim.push_back(random_vector());

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to be sent and every result to arrive
        while (stim_idx < vec_stim.size() || in_ch.valid || pending_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending_angles.size() == 0) begin
            $display("tb_vector_angle_full_turn_top OK");
        end else begin
            $display("tb_vector_angle_full_turn_top NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/vaft_pkg.sv
sv/vaft_if.sv
sv/vaft_prerot.sv
sv/vaft_cordic.sv
sv/vaft_finish.sv
sv/vector_angle_full_turn_top.sv
sim/tb_vector_angle_full_turn_top.sv
